// File: src/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, constants and the per-byte CRC-16 step for the channel frame
// receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int HDR_LEN = 3;
    localparam int CRC_LEN = 2;
    localparam int CH_BYTES = 8;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] HDR_CHAR_A = 8'h41;
    localparam logic [7:0] HDR_CHAR_N = 8'h4E;
    localparam logic [7:0] HDR_CHAR_S = 8'h53;

    typedef logic [1:0] frame_status_t;
    localparam frame_status_t FRAME_OK = 2'd0;
    localparam frame_status_t HDR_BAD  = 2'd1;
    localparam frame_status_t CRC_BAD  = 2'd2;

    typedef struct packed {
        logic          valid;
        frame_status_t status;
    } frame_done_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = HDR_CHAR_A;
            2'd1:    ch = HDR_CHAR_N;
            2'd2:    ch = HDR_CHAR_S;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: src/channel_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// channel_frame_receiver_top
// Receives framed serial bytes ("ANS" header, CHANNELS x 8 payload bytes,
// CRC-16/Modbus low byte first) and returns one item per channel, or one
// error item, at the end of each frame.
//
//   channel   dir   handshake           payload
//   s_        in    s_valid/s_ready     s_rx_byte, s_frame_start
//   m_        out   m_valid/m_ready     m_channel_index .. m_last_of_frame
//
// One byte is taken every cycle while s_ready is high. A frame's items are
// queued with its last byte and leave through the output register at one per
// cycle if m_ready allows. s_ready drops only when a frame's last byte is due
// while items of the previous frame are not all in the output register yet.
// Synchronous active-low reset; no clearing pass, payload store is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module channel_frame_receiver_top
    import cfr_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_frame_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_channel_index,
    output logic [18:0]      m_raw_reading,
    output logic [31:0]      m_calibrated_word,
    output logic [3:0]       m_gain_code,
    output logic             m_raw_positive,
    output logic [1:0]       m_frame_status,
    output logic             m_last_of_frame
);

    frame_done_t frame_done;
    logic        at_last;
    logic        q_busy;
    logic [CH_BYTES*CHANNELS-1:0][BYTE_W-1:0] payload;

    assign s_ready = !(at_last && q_busy);

    cfr_parser #(
        .CHANNELS(CHANNELS)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_valid && s_ready),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .done        (frame_done),
        .at_last     (at_last),
        .payload     (payload)
    );

    cfr_result_queue #(
        .CHANNELS(CHANNELS)
    ) u_queue (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .done              (frame_done),
        .payload           (payload),
        .busy              (q_busy),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_channel_index   (m_channel_index),
        .m_raw_reading     (m_raw_reading),
        .m_calibrated_word (m_calibrated_word),
        .m_gain_code       (m_gain_code),
        .m_raw_positive    (m_raw_positive),
        .m_frame_status    (m_frame_status),
        .m_last_of_frame   (m_last_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_done_queue_free: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done.valid |-> !q_busy)
        else $error("frame completed while results still queued");

    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (q_busy && at_last))
        else $error("input stalled without pending results");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_frame_status != FRAME_OK)) |-> m_last_of_frame)
        else $error("error item not marked last");

    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_frame && (m_frame_status == FRAME_OK))
            |-> (m_channel_index == 2'(CHANNELS - 1)))
        else $error("good frame ended on wrong channel");
`endif

endmodule

`default_nettype wire

// File: src/cfr_parser.sv
// ----------------------------------------------------------------------------
// cfr_parser
// Byte-by-byte frame tracker: header check, running CRC-16/Modbus, capture of
// the channel payload, and the frame verdict on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfr_parser
    import cfr_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   byte_accept,
    input  wire logic [BYTE_W-1:0]                      rx_byte,
    input  wire logic                                   frame_start,
    output frame_done_t                                 done,
    output logic                                        at_last,
    output logic [CH_BYTES*CHANNELS-1:0][BYTE_W-1:0]    payload
);

    localparam int PAY_LEN   = CH_BYTES * CHANNELS;
    localparam int FRAME_LEN = HDR_LEN + PAY_LEN + CRC_LEN;
    localparam int POS_W     = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = $clog2(PAY_LEN);

    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HDR_LEN);
    localparam logic [POS_W-1:0] POS_PAY_END = POS_W'(HDR_LEN + PAY_LEN);
    localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_IDLE    = POS_W'(FRAME_LEN);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [15:0]       crc_reg, crc_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic [7:0]        crc_low_reg, crc_low_next;
    logic [BYTE_W-1:0] chan_bytes_reg [PAY_LEN];

    logic [POS_W-1:0]  pos_eff;
    logic [15:0]       crc_eff;
    logic              hdr_eff;
    logic [15:0]       crc_upd;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    always_comb begin
        pos_eff = frame_start ? '0 : pos_reg;
        crc_eff = frame_start ? CRC_INIT : crc_reg;
        hdr_eff = frame_start ? 1'b1 : hdr_ok_reg;
        crc_upd = crc16_byte(crc_eff, rx_byte);
        wr_idx  = IDX_W'(pos_eff - POS_HDR_END);

        pos_next     = pos_reg;
        crc_next     = crc_reg;
        hdr_ok_next  = hdr_ok_reg;
        crc_low_next = crc_low_reg;
        wr_en        = 1'b0;
        done         = '{valid: 1'b0, status: FRAME_OK};

        if (byte_accept && (pos_eff < POS_IDLE)) begin
            pos_next    = pos_eff + POS_W'(1);
            crc_next    = crc_eff;
            hdr_ok_next = hdr_eff;
            if (pos_eff < POS_HDR_END) begin
                if (rx_byte != hdr_char(pos_eff[1:0])) begin
                    hdr_ok_next = 1'b0;
                end
                crc_next = crc_upd;
            end else if (pos_eff < POS_PAY_END) begin
                wr_en    = 1'b1;
                crc_next = crc_upd;
            end else if (pos_eff == POS_CRC_LO) begin
                crc_low_next = rx_byte;
            end else begin
                done.valid = 1'b1;
                if (!hdr_eff) begin
                    done.status = HDR_BAD;
                end else if ((crc_low_reg != crc_eff[7:0]) ||
                             (rx_byte != crc_eff[15:8])) begin
                    done.status = CRC_BAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_IDLE;
            crc_reg     <= CRC_INIT;
            hdr_ok_reg  <= 1'b1;
            crc_low_reg <= '0;
        end else begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            hdr_ok_reg  <= hdr_ok_next;
            crc_low_reg <= crc_low_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            chan_bytes_reg[wr_idx] <= rx_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < PAY_LEN; i++) begin
            payload[i] = chan_bytes_reg[i];
        end
    end

    assign at_last = (pos_reg == POS_LAST);

endmodule

`default_nettype wire

// File: src/cfr_result_queue.sv
// ----------------------------------------------------------------------------
// cfr_result_queue
// Holds a copy of a finished frame and hands its results out one per cycle
// through the output register while m_ready allows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cfr_result_queue
    import cfr_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  frame_done_t                                 done,
    input  wire logic [CH_BYTES*CHANNELS-1:0][BYTE_W-1:0] payload,
    output logic                                        busy,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [1:0]                                  m_channel_index,
    output logic [18:0]                                 m_raw_reading,
    output logic [31:0]                                 m_calibrated_word,
    output logic [3:0]                                  m_gain_code,
    output logic                                        m_raw_positive,
    output logic [1:0]                                  m_frame_status,
    output logic                                        m_last_of_frame
);

    localparam int CNT_W = $clog2(CHANNELS + 1);

    logic [CHANNELS-1:0][CH_BYTES-1:0][BYTE_W-1:0] shadow_reg;
    logic [CNT_W-1:0]  pend_cnt_reg;
    logic [1:0]        ch_idx_reg;
    frame_status_t     status_reg;

    logic              m_valid_reg;
    logic [1:0]        m_channel_index_reg;
    logic [18:0]       m_raw_reading_reg;
    logic [31:0]       m_calibrated_word_reg;
    logic [3:0]        m_gain_code_reg;
    logic              m_raw_positive_reg;
    frame_status_t     m_frame_status_reg;
    logic              m_last_of_frame_reg;

    logic              load_out;
    logic [CH_BYTES-1:0][BYTE_W-1:0] head;

    assign busy     = (pend_cnt_reg != '0);
    assign load_out = busy && (!m_valid_reg || m_ready);
    assign head     = shadow_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (done.valid) begin
                pend_cnt_reg <= (done.status == FRAME_OK) ? CNT_W'(CHANNELS) : CNT_W'(1);
            end else if (load_out) begin
                pend_cnt_reg <= pend_cnt_reg - CNT_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // done only arrives with the queue empty, so it never meets load_out
    always_ff @(posedge aclk) begin
        if (done.valid) begin
            status_reg <= done.status;
            ch_idx_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                for (int k = 0; k < CH_BYTES; k++) begin
                    shadow_reg[c][k] <= payload[c*CH_BYTES + k];
                end
            end
        end else if (load_out) begin
            ch_idx_reg <= ch_idx_reg + 2'd1;
            for (int c = 0; c < CHANNELS - 1; c++) begin
                shadow_reg[c] <= shadow_reg[c+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_frame_status_reg  <= status_reg;
            m_last_of_frame_reg <= (pend_cnt_reg == CNT_W'(1));
            if (status_reg == FRAME_OK) begin
                m_channel_index_reg   <= ch_idx_reg;
                m_raw_reading_reg     <= {head[0], head[1], head[2][7:5]};
                m_calibrated_word_reg <= {head[6], head[5], head[4], head[3]};
                m_gain_code_reg       <= head[7][3:0];
                m_raw_positive_reg    <= head[7][4];
            end else begin
                m_channel_index_reg   <= '0;
                m_raw_reading_reg     <= '0;
                m_calibrated_word_reg <= '0;
                m_gain_code_reg       <= '0;
                m_raw_positive_reg    <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_channel_index   = m_channel_index_reg;
    assign m_raw_reading     = m_raw_reading_reg;
    assign m_calibrated_word = m_calibrated_word_reg;
    assign m_gain_code       = m_gain_code_reg;
    assign m_raw_positive    = m_raw_positive_reg;
    assign m_frame_status    = m_frame_status_reg;
    assign m_last_of_frame   = m_last_of_frame_reg;

endmodule

`default_nettype wire
